FILE: rtl/core/arp_pkg.sv
// Shared types, constants and helper functions of the audio ring packetiser.
`timescale 1ns / 1ps

package arp_pkg;

  // Default number of ring entries; the ring holds one fewer than this.
  localparam int RingDepth  = 256;
  // Longest packet in frames.
  localparam int FrameLimit = 64;
  // Width of a frame count and of the configuration registers.
  localparam int FrameW     = 7;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_STORED   = 3'd0,
    KIND_OVERRUN  = 3'd1,
    KIND_FRAME    = 3'd2,
    KIND_REJECTED = 3'd3,
    KIND_CLEARED  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    REG_MIN_FRAMES     = 2'd0,
    REG_NOMINAL_FRAMES = 2'd1,
    REG_MAX_FRAMES     = 2'd2
  } reg_idx_e;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic [FrameW-1:0] min_frames;
    logic [FrameW-1:0] nominal_frames;
    logic [FrameW-1:0] max_frames;
  } cfg_t;

  // Clamp a packet length into one to FrameLimit frames.
  function automatic logic [FrameW-1:0] limit_len(input logic [FrameW-1:0] n);
    logic [FrameW-1:0] r;
    if (n == '0) begin
      r = FrameW'(1);
    end else if (n > FrameW'(FrameLimit)) begin
      r = FrameW'(FrameLimit);
    end else begin
      r = n;
    end
    return r;
  endfunction

  // Sample divided by 256, rounded toward zero: floor shift plus one for a
  // negative value with a non-zero remainder.
  function automatic logic signed [23:0] pcm24(input logic [31:0] s);
    logic [23:0] q;
    q = s[31:8];
    if (s[31] && (s[7:0] != 8'd0)) begin
      q = q + 24'd1;
    end
    return signed'(q);
  endfunction

endpackage

FILE: rtl/core/arp_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface arp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] sample;
  logic [9:0]         room_bytes;

  modport source (output valid, operation, sample, room_bytes, input ready);
  modport sink   (input valid, operation, sample, room_bytes, output ready);
endinterface

interface arp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [23:0] pcm;
  logic               padded;
  logic               last;
  logic [6:0]         packet_frames;
  logic [7:0]         fill_level;
  logic [31:0]        overrun_count;
  logic [31:0]        underrun_count;
  logic [31:0]        captured_count;
  logic [31:0]        streamed_count;

  modport source (output valid, kind, pcm, padded, last, packet_frames, fill_level,
                  overrun_count, underrun_count, captured_count, streamed_count,
                  input ready);
  modport sink   (input valid, kind, pcm, padded, last, packet_frames, fill_level,
                  overrun_count, underrun_count, captured_count, streamed_count,
                  output ready);
endinterface

FILE: rtl/core/audio_ring_adaptive_packetizer.sv
// Top level of the adaptive audio sample ring and 24-bit packetiser.
`timescale 1ns / 1ps

// One item is taken at a time. A push, a clear or a rejected request is captured
// at transfer and then executed, loading its result when the output is free.
// An accepted packet request issues the first read of the sample memory on
// execution and then streams one frame per cycle while the output takes them,
// paced by the single read port of the sample memory, whose registered read
// lies ahead of the first frame. Stalls on the result side hold the stream.
// The ring keeps RING_DEPTH - 1 samples at most and needs no clearing after reset.

module audio_ring_adaptive_packetizer #(
  parameter int RING_DEPTH = arp_pkg::RingDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  arp_in_if.sink                    in_i,
  arp_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [arp_pkg::FrameW-1:0] cfg_data_i
);
  import arp_pkg::*;

  localparam int PtrW = $clog2(RING_DEPTH);

  cfg_t            cfg_q;
  logic            mem_we, mem_re;
  logic [PtrW-1:0] mem_waddr, mem_raddr;
  logic [31:0]     mem_wdata, mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_frames     <= FrameW'(47);
      cfg_q.nominal_frames <= FrameW'(48);
      cfg_q.max_frames     <= FrameW'(49);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MIN_FRAMES:     cfg_q.min_frames     <= cfg_data_i;
        REG_NOMINAL_FRAMES: cfg_q.nominal_frames <= cfg_data_i;
        REG_MAX_FRAMES:     cfg_q.max_frames     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  arp_ctrl #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  arp_ring_mem #(
    .RING_DEPTH(RING_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // An item is executed before another one can be taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again straight after a transfer");

  // Zero fill appears only in packet frames and carries a zero value.
  a_pad_is_zero_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.padded) |-> (out_o.kind == KIND_FRAME && out_o.pcm == '0))
    else $error("padding outside a packet frame or with a non-zero value");

  // Packet frames report a length within the legal range.
  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_FRAME) |->
      (out_o.packet_frames != '0 && out_o.packet_frames <= FrameW'(FrameLimit)))
    else $error("packet length out of range");

  // Every single-result item closes with its only result.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != KIND_FRAME) |->
      (out_o.last && out_o.packet_frames == '0))
    else $error("single result without last flag");

endmodule

FILE: rtl/core/arp_ring_mem.sv
// Sample ring storage: one write port and one registered read port.
`timescale 1ns / 1ps

module arp_ring_mem #(
  parameter int RING_DEPTH = arp_pkg::RingDepth
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(RING_DEPTH)-1:0] waddr_i,
  input  logic [31:0]                   wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(RING_DEPTH)-1:0] raddr_i,
  output logic [31:0]                   rdata_o
);

  logic [31:0] mem_q [RING_DEPTH];
  logic [31:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/arp_ctrl.sv
// Sequencer: pointers, counters, packet sizing, frame streaming and result register.
`timescale 1ns / 1ps

module arp_ctrl #(
  parameter int RING_DEPTH = arp_pkg::RingDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  arp_pkg::cfg_t                 cfg_i,
  arp_in_if.sink                        in_i,
  arp_out_if.source                     out_o,
  output logic                          mem_we_o,
  output logic [$clog2(RING_DEPTH)-1:0] mem_waddr_o,
  output logic [31:0]                   mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(RING_DEPTH)-1:0] mem_raddr_o,
  input  logic [31:0]                   mem_rdata_i
);
  import arp_pkg::*;

  localparam int PtrW = $clog2(RING_DEPTH);
  localparam int CmpW = ((PtrW > 9) ? PtrW : 9) + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_FRAME = 2'd2;

  logic [1:0]         state_q, state_d;
  op_e                op_q, op_d;
  logic [31:0]        sample_q, sample_d;
  logic [9:0]         room_q, room_d;
  logic [PtrW-1:0]    rp_q, rp_d, wp_q, wp_d, base_q, base_d;
  logic [31:0]        ovr_q, ovr_d, und_q, und_d, cap_q, cap_d, str_q, str_d;
  logic [FrameW-1:0]  frames_q, frames_d, take_q, take_d, idx_q, idx_d;

  logic               ovalid_q, ovalid_d;
  kind_e              okind_q, okind_d;
  logic signed [23:0] opcm_q, opcm_d;
  logic               opad_q, opad_d, olast_q, olast_d;
  logic [FrameW-1:0]  oframes_q, oframes_d;
  logic [7:0]         ofill_q, ofill_d;
  logic [31:0]        oovr_q, oovr_d, ound_q, ound_d, ocap_q, ocap_d, ostr_q, ostr_d;

  logic               slot_free, load;
  kind_e              lkind;
  logic signed [23:0] lpcm;
  logic               lpad, llast;
  logic [FrameW-1:0]  lframes;
  logic [PtrW-1:0]    avail, fill_next;
  logic [8:0]         nom3;
  logic [9:0]         need_room;
  logic [FrameW-1:0]  pick, len;

  assign in_i.ready = (state_q == ST_IDLE);
  assign slot_free  = !ovalid_q || out_o.ready;

  // Packet sizing from the fill level before the request.
  always_comb begin
    avail     = wp_q - rp_q;
    nom3      = 9'(cfg_i.nominal_frames) * 9'd3;
    need_room = 10'(limit_len(cfg_i.max_frames)) * 10'd3;
    if (CmpW'(avail) > CmpW'(nom3)) begin
      pick = cfg_i.max_frames;
    end else if (CmpW'(avail) < CmpW'(cfg_i.nominal_frames)) begin
      pick = cfg_i.min_frames;
    end else begin
      pick = cfg_i.nominal_frames;
    end
    len = limit_len(pick);
  end

  // Next-state logic of the sequencer and the result register.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    sample_d  = sample_q;
    room_d    = room_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    base_d    = base_q;
    ovr_d     = ovr_q;
    und_d     = und_q;
    cap_d     = cap_q;
    str_d     = str_q;
    frames_d  = frames_q;
    take_d    = take_q;
    idx_d     = idx_q;
    mem_we_o  = 1'b0;
    mem_re_o  = 1'b0;
    mem_raddr_o = base_q + PtrW'(idx_q + FrameW'(1));
    load      = 1'b0;
    lkind     = KIND_STORED;
    lpcm      = '0;
    lpad      = 1'b0;
    llast     = 1'b1;
    lframes   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          op_d     = op_e'(in_i.operation);
          sample_d = in_i.sample;
          room_d   = in_i.room_bytes;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (op_q)
          OP_PUSH: begin
            if (slot_free) begin
              load    = 1'b1;
              state_d = ST_IDLE;
              if (wp_q + PtrW'(1) == rp_q) begin
                ovr_d = ovr_q + 32'd1;
                lkind = KIND_OVERRUN;
              end else begin
                mem_we_o = 1'b1;
                wp_d     = wp_q + PtrW'(1);
                cap_d    = cap_q + 32'd1;
                lkind    = KIND_STORED;
              end
            end
          end
          OP_REQUEST: begin
            if (room_q < need_room) begin
              if (slot_free) begin
                load    = 1'b1;
                lkind   = KIND_REJECTED;
                state_d = ST_IDLE;
              end
            end else begin
              // Commit the whole packet now; frames then stream from base_q.
              take_d      = (CmpW'(avail) < CmpW'(len)) ? FrameW'(avail) : len;
              frames_d    = len;
              idx_d       = '0;
              base_d      = rp_q;
              rp_d        = rp_q + PtrW'(take_d);
              und_d       = (take_d < len) ? und_q + 32'd1 : und_q;
              str_d       = str_q + 32'(len);
              mem_re_o    = 1'b1;
              mem_raddr_o = rp_q;
              state_d     = ST_FRAME;
            end
          end
          OP_CLEAR: begin
            if (slot_free) begin
              rp_d    = '0;
              wp_d    = '0;
              ovr_d   = '0;
              und_d   = '0;
              cap_d   = '0;
              str_d   = '0;
              load    = 1'b1;
              lkind   = KIND_CLEARED;
              state_d = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_FRAME: begin
        // One frame per transfer; the next read is issued only when one is loaded.
        if (slot_free) begin
          load    = 1'b1;
          lkind   = KIND_FRAME;
          lpad    = (idx_q >= take_q);
          lpcm    = lpad ? '0 : pcm24(mem_rdata_i);
          llast   = (idx_q == frames_q - FrameW'(1));
          lframes = frames_q;
          if (llast) begin
            state_d = ST_IDLE;
          end else begin
            idx_d    = idx_q + FrameW'(1);
            mem_re_o = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    fill_next = wp_d - rp_d;

    // Result register: cleared on transfer, reloaded with the post-step state.
    ovalid_d  = ovalid_q && !out_o.ready;
    okind_d   = okind_q;
    opcm_d    = opcm_q;
    opad_d    = opad_q;
    olast_d   = olast_q;
    oframes_d = oframes_q;
    ofill_d   = ofill_q;
    oovr_d    = oovr_q;
    ound_d    = ound_q;
    ocap_d    = ocap_q;
    ostr_d    = ostr_q;
    if (load) begin
      ovalid_d  = 1'b1;
      okind_d   = lkind;
      opcm_d    = lpcm;
      opad_d    = lpad;
      olast_d   = llast;
      oframes_d = lframes;
      ofill_d   = 8'(fill_next);
      oovr_d    = ovr_d;
      ound_d    = und_d;
      ocap_d    = cap_d;
      ostr_d    = str_d;
    end
  end

  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = sample_q;

  // Control state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rp_q     <= '0;
      wp_q     <= '0;
      ovr_q    <= '0;
      und_q    <= '0;
      cap_q    <= '0;
      str_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      ovr_q    <= ovr_d;
      und_q    <= und_d;
      cap_q    <= cap_d;
      str_q    <= str_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    sample_q  <= sample_d;
    room_q    <= room_d;
    base_q    <= base_d;
    frames_q  <= frames_d;
    take_q    <= take_d;
    idx_q     <= idx_d;
    okind_q   <= okind_d;
    opcm_q    <= opcm_d;
    opad_q    <= opad_d;
    olast_q   <= olast_d;
    oframes_q <= oframes_d;
    ofill_q   <= ofill_d;
    oovr_q    <= oovr_d;
    ound_q    <= ound_d;
    ocap_q    <= ocap_d;
    ostr_q    <= ostr_d;
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.kind           = okind_q;
  assign out_o.pcm            = opcm_q;
  assign out_o.padded         = opad_q;
  assign out_o.last           = olast_q;
  assign out_o.packet_frames  = oframes_q;
  assign out_o.fill_level     = ofill_q;
  assign out_o.overrun_count  = oovr_q;
  assign out_o.underrun_count = ound_q;
  assign out_o.captured_count = ocap_q;
  assign out_o.streamed_count = ostr_q;

endmodule
